@@ hw/rtl/sit_pkg.sv @@
`default_nettype none

package sit_pkg;

    // Port field widths are fixed; internal datapath width follows COORD_BITS.
    localparam int IN_BITS  = 16;
    localparam int TOL_BITS = 16;
    localparam logic [TOL_BITS-1:0] TOL_RESET = 16'd16;

    // Number of coordinates in one input beat.
    localparam int NUM_COORDS = 8;

    typedef struct packed {
        logic signed [IN_BITS-1:0] a_start_x;
        logic signed [IN_BITS-1:0] a_start_y;
        logic signed [IN_BITS-1:0] a_end_x;
        logic signed [IN_BITS-1:0] a_end_y;
        logic signed [IN_BITS-1:0] b_start_x;
        logic signed [IN_BITS-1:0] b_start_y;
        logic signed [IN_BITS-1:0] b_end_x;
        logic signed [IN_BITS-1:0] b_end_y;
    } sit_in_t;

    typedef struct packed {
        logic intersects;
        logic parallel;
        logic status;
    } sit_out_t;

    // Control that travels alongside the pipeline data.
    typedef struct packed {
        logic valid;
        logic degen;
        logic par_hit;
    } sit_ctrl_t;

endpackage

`default_nettype wire

@@ hw/rtl/sit_line_calc.sv @@
`default_nettype none

// Stages 1-3: line coefficients, determinant, numerator products and the
// parallel-case hit test (residual plus box test).
module sit_line_calc #(
    parameter int W = 16,
    parameter int F = 16
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    input  wire logic signed [W-1:0]          coord [sit_pkg::NUM_COORDS],
    input  wire logic [sit_pkg::TOL_BITS-1:0] tol,
    output sit_pkg::sit_ctrl_t                ctrl,
    output logic signed [2*W+2:0]             det,
    output logic signed [3*W+1:0]             prod [4],
    output logic signed [W-1:0]               lox [2],
    output logic signed [W-1:0]               hix [2],
    output logic signed [W-1:0]               loy [2],
    output logic signed [W-1:0]               hiy [2]
);
    import sit_pkg::*;

    localparam int BW = W + F + 2;
    localparam int RW = 2 * W + 3;

    function automatic logic pt_in_box(
        input logic signed [W-1:0] px,
        input logic signed [W-1:0] py,
        input logic signed [W-1:0] bx0,
        input logic signed [W-1:0] bx1,
        input logic signed [W-1:0] by0,
        input logic signed [W-1:0] by1,
        input logic [TOL_BITS-1:0] t
    );
        logic signed [BW-1:0] tt, dxl, dxh, dyl, dyh;
        tt  = $signed({{(BW-TOL_BITS){1'b0}}, t});
        dxl = (BW'(px) - BW'(bx0)) <<< F;
        dxh = (BW'(px) - BW'(bx1)) <<< F;
        dyl = (BW'(py) - BW'(by0)) <<< F;
        dyh = (BW'(py) - BW'(by1)) <<< F;
        return (dxl + tt >= 0) && (dxh <= tt) && (dyl + tt >= 0) && (dyh <= tt);
    endfunction

    // ---------------- stage 1 ----------------
    logic                  s1_valid_reg, s1_deg_reg;
    logic signed [W-1:0]   s1_c_reg [NUM_COORDS];
    logic signed [W:0]     s1_a_reg [2];
    logic signed [W:0]     s1_b_reg [2];
    logic signed [2*W-1:0] s1_p0_reg [2];
    logic signed [2*W-1:0] s1_p1_reg [2];

    logic signed [W:0]     s1_a_next [2];
    logic signed [W:0]     s1_b_next [2];
    logic signed [2*W-1:0] s1_p0_next [2];
    logic signed [2*W-1:0] s1_p1_next [2];
    logic                  s1_deg_next;

    always_comb
    begin
        s1_deg_next = 1'b0;
        for (int k = 0; k < 2; k++)
        begin
            s1_a_next[k]  = (W+1)'(coord[4*k+1]) - (W+1)'(coord[4*k+3]);
            s1_b_next[k]  = (W+1)'(coord[4*k+2]) - (W+1)'(coord[4*k]);
            s1_p0_next[k] = coord[4*k] * coord[4*k+3];
            s1_p1_next[k] = coord[4*k+2] * coord[4*k+1];
            if (coord[4*k] == coord[4*k+2] && coord[4*k+1] == coord[4*k+3])
            begin
                s1_deg_next = 1'b1;
            end
        end
    end

    // ---------------- stage 2 ----------------
    logic                  s2_valid_reg, s2_deg_reg;
    logic signed [2*W:0]   s2_cc_reg [2];
    logic signed [2*W+1:0] s2_dp_reg [2];
    logic signed [2*W:0]   s2_rpa_reg [4];
    logic signed [2*W:0]   s2_rpb_reg [4];
    logic [3:0]            s2_box_reg;
    logic signed [W:0]     s2_a_reg [2];
    logic signed [W:0]     s2_b_reg [2];
    logic signed [W-1:0]   s2_lox_reg [2];
    logic signed [W-1:0]   s2_hix_reg [2];
    logic signed [W-1:0]   s2_loy_reg [2];
    logic signed [W-1:0]   s2_hiy_reg [2];

    logic signed [2*W:0]   s2_cc_next [2];
    logic signed [2*W+1:0] s2_dp_next [2];
    logic signed [2*W:0]   s2_rpa_next [4];
    logic signed [2*W:0]   s2_rpb_next [4];
    logic [3:0]            s2_box_next;
    logic signed [W-1:0]   s2_lox_next [2];
    logic signed [W-1:0]   s2_hix_next [2];
    logic signed [W-1:0]   s2_loy_next [2];
    logic signed [W-1:0]   s2_hiy_next [2];

    always_comb
    begin
        for (int k = 0; k < 2; k++)
        begin
            s2_cc_next[k] = (2*W+1)'(s1_p0_reg[k]) - (2*W+1)'(s1_p1_reg[k]);
            s2_lox_next[k] = (s1_c_reg[4*k] < s1_c_reg[4*k+2]) ? s1_c_reg[4*k] : s1_c_reg[4*k+2];
            s2_hix_next[k] = (s1_c_reg[4*k] > s1_c_reg[4*k+2]) ? s1_c_reg[4*k] : s1_c_reg[4*k+2];
            s2_loy_next[k] = (s1_c_reg[4*k+1] < s1_c_reg[4*k+3]) ? s1_c_reg[4*k+1]
                                                                  : s1_c_reg[4*k+3];
            s2_hiy_next[k] = (s1_c_reg[4*k+1] > s1_c_reg[4*k+3]) ? s1_c_reg[4*k+1]
                                                                  : s1_c_reg[4*k+3];
        end
        s2_dp_next[0] = s1_a_reg[0] * s1_b_reg[1];
        s2_dp_next[1] = s1_a_reg[1] * s1_b_reg[0];
        // checks 0,1: b endpoints on line a; checks 2,3: a endpoints on line b
        for (int j = 0; j < 4; j++)
        begin
            s2_rpa_next[j] = s1_a_reg[j/2] * s1_c_reg[(j < 2 ? 4 : 0) + 2*(j%2)];
            s2_rpb_next[j] = s1_b_reg[j/2] * s1_c_reg[(j < 2 ? 4 : 0) + 2*(j%2) + 1];
            s2_box_next[j] = pt_in_box(s1_c_reg[(j < 2 ? 4 : 0) + 2*(j%2)],
                                       s1_c_reg[(j < 2 ? 4 : 0) + 2*(j%2) + 1],
                                       s2_lox_next[j/2], s2_hix_next[j/2],
                                       s2_loy_next[j/2], s2_hiy_next[j/2], tol);
        end
    end

    // ---------------- stage 3 ----------------
    logic                  s3_valid_reg, s3_deg_reg, s3_hit_reg;
    logic signed [2*W+2:0] s3_det_reg;
    logic signed [3*W+1:0] s3_q_reg [4];
    logic signed [W-1:0]   s3_lox_reg [2];
    logic signed [W-1:0]   s3_hix_reg [2];
    logic signed [W-1:0]   s3_loy_reg [2];
    logic signed [W-1:0]   s3_hiy_reg [2];

    logic signed [3*W+1:0] s3_q_next [4];
    logic signed [RW-1:0]  r_sum [4];
    logic signed [RW-1:0]  ti;
    logic                  s3_hit_next;

    always_comb
    begin
        ti = $signed({{(RW-TOL_BITS){1'b0}}, tol >> F});
        s3_hit_next = 1'b0;
        for (int j = 0; j < 4; j++)
        begin
            r_sum[j] = RW'(s2_rpa_reg[j]) + RW'(s2_rpb_reg[j]) + RW'(s2_cc_reg[j/2]);
            if (r_sum[j] <= ti && r_sum[j] >= -ti && s2_box_reg[j])
            begin
                s3_hit_next = 1'b1;
            end
        end
        // nx = Ba*Cb - Bb*Ca ; ny = Ab*Ca - Aa*Cb
        s3_q_next[0] = s2_b_reg[0] * s2_cc_reg[1];
        s3_q_next[1] = s2_b_reg[1] * s2_cc_reg[0];
        s3_q_next[2] = s2_a_reg[1] * s2_cc_reg[0];
        s3_q_next[3] = s2_a_reg[0] * s2_cc_reg[1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_c_reg   <= coord;
        s1_a_reg   <= s1_a_next;
        s1_b_reg   <= s1_b_next;
        s1_p0_reg  <= s1_p0_next;
        s1_p1_reg  <= s1_p1_next;
        s1_deg_reg <= s1_deg_next;

        s2_cc_reg  <= s2_cc_next;
        s2_dp_reg  <= s2_dp_next;
        s2_rpa_reg <= s2_rpa_next;
        s2_rpb_reg <= s2_rpb_next;
        s2_box_reg <= s2_box_next;
        s2_a_reg   <= s1_a_reg;
        s2_b_reg   <= s1_b_reg;
        s2_lox_reg <= s2_lox_next;
        s2_hix_reg <= s2_hix_next;
        s2_loy_reg <= s2_loy_next;
        s2_hiy_reg <= s2_hiy_next;
        s2_deg_reg <= s1_deg_reg;

        s3_det_reg <= (2*W+3)'(s2_dp_reg[0]) - (2*W+3)'(s2_dp_reg[1]);
        s3_q_reg   <= s3_q_next;
        s3_hit_reg <= s3_hit_next;
        s3_lox_reg <= s2_lox_reg;
        s3_hix_reg <= s2_hix_reg;
        s3_loy_reg <= s2_loy_reg;
        s3_hiy_reg <= s2_hiy_reg;
        s3_deg_reg <= s2_deg_reg;
    end

    assign ctrl.valid   = s3_valid_reg;
    assign ctrl.degen   = s3_deg_reg;
    assign ctrl.par_hit = s3_hit_reg;
    assign det  = s3_det_reg;
    assign prod = s3_q_reg;
    assign lox  = s3_lox_reg;
    assign hix  = s3_hix_reg;
    assign loy  = s3_loy_reg;
    assign hiy  = s3_hiy_reg;

endmodule

`default_nettype wire

@@ hw/rtl/sit_decide.sv @@
`default_nettype none

// Stages 4-6: crossing numerators, bound products and the truncating-
// quotient box test done as exact cross-multiplied compares.
module sit_decide #(
    parameter int W = 16,
    parameter int F = 16
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire sit_pkg::sit_ctrl_t           ctrl,
    input  wire logic signed [2*W+2:0]        det,
    input  wire logic signed [3*W+1:0]        prod [4],
    input  wire logic signed [W-1:0]          lox [2],
    input  wire logic signed [W-1:0]          hix [2],
    input  wire logic signed [W-1:0]          loy [2],
    input  wire logic signed [W-1:0]          hiy [2],
    input  wire logic [sit_pkg::TOL_BITS-1:0] tol,
    output logic                              out_valid,
    output sit_pkg::sit_out_t                 out_data
);
    import sit_pkg::*;

    localparam int NW = 3 * W + 3;
    localparam int MW = 2 * W + 4;
    localparam int PW = 3 * W + 4;
    localparam int TW = 2 * W + 21;
    localparam int SW = 3 * W + F + 6;

    // q = trunc(n*2^F/d) against [lo*2^F - t, hi*2^F + t], d > 0
    function automatic logic bound_ok(
        input logic signed [NW-1:0] n,
        input logic signed [PW-1:0] plo,
        input logic signed [PW-1:0] phi,
        input logic signed [TW-1:0] td,
        input logic signed [MW-1:0] d
    );
        logic signed [SW-1:0] ns, ld, hd, ds;
        ns = SW'(n) <<< F;
        ld = (SW'(plo) <<< F) - SW'(td);
        hd = (SW'(phi) <<< F) + SW'(td);
        ds = SW'(d);
        if (!ns[SW-1])
            return (ns >= ld) && (ns < hd + ds);
        else
            return (ns > ld - ds) && (ns <= hd);
    endfunction

    // ---------------- stage 4 ----------------
    sit_ctrl_t            s4_ctrl_reg;
    logic                 s4_par_reg;
    logic signed [MW-1:0] s4_d_reg;
    logic signed [NW-1:0] s4_nx_reg, s4_ny_reg;
    logic signed [W-1:0]  s4_lox_reg [2];
    logic signed [W-1:0]  s4_hix_reg [2];
    logic signed [W-1:0]  s4_loy_reg [2];
    logic signed [W-1:0]  s4_hiy_reg [2];

    logic                 neg;
    logic signed [MW-1:0] s4_d_next;
    logic signed [NW-1:0] s4_nx_next, s4_ny_next;
    logic                 s4_par_next;

    always_comb
    begin
        neg = det[2*W+2];
        s4_d_next = neg ? -MW'(det) : MW'(det);
        s4_par_next = s4_d_next <= $signed({{(MW-TOL_BITS){1'b0}}, tol >> F});
        s4_nx_next = neg ? NW'(prod[1]) - NW'(prod[0]) : NW'(prod[0]) - NW'(prod[1]);
        s4_ny_next = neg ? NW'(prod[3]) - NW'(prod[2]) : NW'(prod[2]) - NW'(prod[3]);
    end

    // ---------------- stage 5 ----------------
    sit_ctrl_t            s5_ctrl_reg;
    logic                 s5_par_reg;
    logic signed [MW-1:0] s5_d_reg;
    logic signed [NW-1:0] s5_nx_reg, s5_ny_reg;
    logic signed [TW-1:0] s5_td_reg;
    logic signed [PW-1:0] s5_plx_reg [2];
    logic signed [PW-1:0] s5_phx_reg [2];
    logic signed [PW-1:0] s5_ply_reg [2];
    logic signed [PW-1:0] s5_phy_reg [2];

    // ---------------- stage 6 ----------------
    logic      s6_valid_reg;
    sit_out_t  s6_out_reg;
    sit_out_t  s6_out_next;
    logic      box_ok;

    always_comb
    begin
        box_ok = 1'b1;
        for (int k = 0; k < 2; k++)
        begin
            if (!bound_ok(s5_nx_reg, s5_plx_reg[k], s5_phx_reg[k], s5_td_reg, s5_d_reg))
                box_ok = 1'b0;
            if (!bound_ok(s5_ny_reg, s5_ply_reg[k], s5_phy_reg[k], s5_td_reg, s5_d_reg))
                box_ok = 1'b0;
        end
        s6_out_next.status     = s5_ctrl_reg.degen;
        s6_out_next.parallel   = !s5_ctrl_reg.degen && s5_par_reg;
        s6_out_next.intersects = !s5_ctrl_reg.degen
                                 && (s5_par_reg ? s5_ctrl_reg.par_hit : box_ok);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_ctrl_reg  <= '0;
            s5_ctrl_reg  <= '0;
            s6_valid_reg <= 1'b0;
        end
        else
        begin
            s4_ctrl_reg  <= ctrl;
            s5_ctrl_reg  <= s4_ctrl_reg;
            s6_valid_reg <= s5_ctrl_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        s4_par_reg <= s4_par_next;
        s4_d_reg   <= s4_d_next;
        s4_nx_reg  <= s4_nx_next;
        s4_ny_reg  <= s4_ny_next;
        s4_lox_reg <= lox;
        s4_hix_reg <= hix;
        s4_loy_reg <= loy;
        s4_hiy_reg <= hiy;

        s5_par_reg <= s4_par_reg;
        s5_d_reg   <= s4_d_reg;
        s5_nx_reg  <= s4_nx_reg;
        s5_ny_reg  <= s4_ny_reg;
        s5_td_reg  <= $signed({1'b0, tol}) * s4_d_reg;
        for (int k = 0; k < 2; k++)
        begin
            s5_plx_reg[k] <= s4_lox_reg[k] * s4_d_reg;
            s5_phx_reg[k] <= s4_hix_reg[k] * s4_d_reg;
            s5_ply_reg[k] <= s4_loy_reg[k] * s4_d_reg;
            s5_phy_reg[k] <= s4_hiy_reg[k] * s4_d_reg;
        end

        s6_out_reg <= s6_out_next;
    end

    assign out_valid = s6_valid_reg;
    assign out_data  = s6_out_reg;

endmodule

`default_nettype wire

@@ hw/rtl/segment_intersection_test_unit.sv @@
`default_nettype none

// Channel   | Ports                        | Beat taken when
// ----------+------------------------------+--------------------------------
// operands  | start, busy, segs            | start high, busy low
// results   | done, result                 | done high (one cycle, no stall)
// tolerance | tol_we, tol_wdata            | tol_we high
//
// Fixed six-stage pipeline: one operand beat per cycle. done rises when the
// beat reaches the stage 6 register, and the result is taken with done high.
// busy is always low. The stages follow the chain line -> determinant ->
// numerator -> bound products -> compares; multipliers sit in stages 1, 2,
// 3 and 5.
// Reset clears the stage valid bits and loads tolerance with 16.
// The receiver cannot stall, so there is no backpressure path.
module segment_intersection_test_unit #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire sit_pkg::sit_in_t             segs,
    output logic                              done,
    output sit_pkg::sit_out_t                 result,
    input  wire logic                         tol_we,
    input  wire logic [sit_pkg::TOL_BITS-1:0] tol_wdata
);
    import sit_pkg::*;

    localparam int W = COORD_BITS;

    logic [TOL_BITS-1:0] tol_reg;

    logic signed [IN_BITS-1:0] field [NUM_COORDS];
    logic signed [W-1:0]       coord [NUM_COORDS];

    sit_ctrl_t             mid_ctrl;
    logic signed [2*W+2:0] mid_det;
    logic signed [3*W+1:0] mid_prod [4];
    logic signed [W-1:0]   mid_lox [2];
    logic signed [W-1:0]   mid_hix [2];
    logic signed [W-1:0]   mid_loy [2];
    logic signed [W-1:0]   mid_hiy [2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= TOL_RESET;
        end
        else if (tol_we)
        begin
            tol_reg <= tol_wdata;
        end
    end

    assign field[0] = segs.a_start_x;
    assign field[1] = segs.a_start_y;
    assign field[2] = segs.a_end_x;
    assign field[3] = segs.a_end_y;
    assign field[4] = segs.b_start_x;
    assign field[5] = segs.b_start_y;
    assign field[6] = segs.b_end_x;
    assign field[7] = segs.b_end_y;

    // Narrow coordinates use the low bits; wide ones sign extend the field.
    generate
        if (COORD_BITS <= IN_BITS)
        begin : g_narrow
            for (genvar i = 0; i < NUM_COORDS; i++)
            begin : g_c
                assign coord[i] = field[i][W-1:0];
            end
        end
        else
        begin : g_wide
            for (genvar i = 0; i < NUM_COORDS; i++)
            begin : g_c
                assign coord[i] = W'(field[i]);
            end
        end
    endgenerate

    assign busy = 1'b0;

    sit_line_calc #(
        .W (COORD_BITS),
        .F (FRAC_BITS)
    ) u_line (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (start && !busy),
        .coord    (coord),
        .tol      (tol_reg),
        .ctrl     (mid_ctrl),
        .det      (mid_det),
        .prod     (mid_prod),
        .lox      (mid_lox),
        .hix      (mid_hix),
        .loy      (mid_loy),
        .hiy      (mid_hiy)
    );

    sit_decide #(
        .W (COORD_BITS),
        .F (FRAC_BITS)
    ) u_decide (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (mid_ctrl),
        .det       (mid_det),
        .prod      (mid_prod),
        .lox       (mid_lox),
        .hix       (mid_hix),
        .loy       (mid_loy),
        .hiy       (mid_hiy),
        .tol       (tol_reg),
        .out_valid (done),
        .out_data  (result)
    );

endmodule

`default_nettype wire

@@ hw/rtl/sit_checker.sv @@
`default_nettype none

module sit_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              start,
    input wire logic              busy,
    input wire logic              done,
    input wire sit_pkg::sit_out_t result
);
    import sit_pkg::*;

    // degenerate segments never report a hit or a parallel pair
    a_degen_clean: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.status |-> !result.intersects && !result.parallel)
        else $error("degenerate result with hit or parallel set");

    // every result traces back to an accepted operand beat
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 6))
        else $error("result without matching operand beat");

    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !done)
        else $error("result strobe during reset");

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("pipeline refused a beat");

endmodule

bind segment_intersection_test_unit sit_checker u_sit_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import sit_pkg::*;

    localparam int FRAC = 16;
    localparam int LATENCY_SLACK = 12;   // pipeline is six stages; margin on top
    localparam longint QUOT_SAT = 64'sd1 << 62;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    sit_in_t             segs;
    logic                done;
    sit_out_t            result;
    logic                tol_we;
    logic [TOL_BITS-1:0] tol_wdata;

    segment_intersection_test_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .segs      (segs),
        .done      (done),
        .result    (result),
        .tol_we    (tol_we),
        .tol_wdata (tol_wdata)
    );

    // Own copy of the tolerance register, tracked on every write.
    logic [TOL_BITS-1:0] tol_shadow;
    sit_out_t            verdicts_pending[$];
    int                  err_count;
    int                  beat_count;
    bit                  idle_enable;

    // One directed row: segments plus an optional hand-written answer.
    typedef struct {
        sit_in_t  pair;
        bit       typed;
        sit_out_t answer;
    } pair_row_t;

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard stop well beyond the slowest correct run.
    initial begin
        #400000;
        $display("Some tests failed");
        $finish;
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] MISMATCH: %s", $realtime, what);
        err_count++;
    endtask

    // ------------------------------------------------------------------
    // Predictor helpers
    // ------------------------------------------------------------------

    // trunc(num * 2^FRAC / den), magnitude saturated at 2^62.
    function automatic longint crossing_coord(logic signed [127:0] num, longint den);
        logic [127:0] mag;
        logic [127:0] quo;
        bit           neg;
        neg = num < 0;
        mag = neg ? -num : num;
        mag = mag << FRAC;
        quo = mag / {64'd0, den};
        if (quo > 128'(QUOT_SAT))
            quo = 128'(QUOT_SAT);
        return neg ? -longint'(quo[63:0]) : longint'(quo[63:0]);
    endfunction

    // Fixed-point point vs segment bounding box, widened by tolerance.
    function automatic bit box_hit(longint x0, longint y0, longint x1, longint y1,
                                   longint xq, longint yq, logic [TOL_BITS-1:0] tol);
        longint t;
        longint sc;
        t  = longint'(tol);
        sc = 64'sd1 << FRAC;
        if (xq < ((x0 < x1) ? x0 : x1) * sc - t) return 1'b0;
        if (xq > ((x0 > x1) ? x0 : x1) * sc + t) return 1'b0;
        if (yq < ((y0 < y1) ? y0 : y1) * sc - t) return 1'b0;
        if (yq > ((y0 > y1) ? y0 : y1) * sc + t) return 1'b0;
        return 1'b1;
    endfunction

    // Integer point on segment: exact residual, then box check.
    function automatic bit point_on_seg(longint x0, longint y0, longint x1, longint y1,
                                        longint px, longint py, logic [TOL_BITS-1:0] tol);
        longint la, lb, lc, r;
        la = y0 - y1;
        lb = x1 - x0;
        lc = x0 * y1 - x1 * y0;
        r  = la * px + lb * py + lc;
        if (r < 0) r = -r;
        if (r > (longint'(tol) >>> FRAC)) return 1'b0;
        return box_hit(x0, y0, x1, y1, px << FRAC, py << FRAC, tol);
    endfunction

    function automatic sit_out_t predict_contact(sit_in_t s, logic [TOL_BITS-1:0] tol);
        longint             ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
        longint             aa, ab, ac, ba, bb, bc, det, dmag, xq, yq;
        logic signed [127:0] nx, ny;
        sit_out_t           v;
        v   = '0;
        ax0 = s.a_start_x; ay0 = s.a_start_y; ax1 = s.a_end_x; ay1 = s.a_end_y;
        bx0 = s.b_start_x; by0 = s.b_start_y; bx1 = s.b_end_x; by1 = s.b_end_y;
        if ((ax0 == ax1 && ay0 == ay1) || (bx0 == bx1 && by0 == by1)) begin
            v.status = 1'b1;
            return v;
        end
        aa = ay0 - ay1; ab = ax1 - ax0; ac = ax0 * ay1 - ax1 * ay0;
        ba = by0 - by1; bb = bx1 - bx0; bc = bx0 * by1 - bx1 * by0;
        det  = aa * bb - ba * ab;
        dmag = (det < 0) ? -det : det;
        if (dmag <= (longint'(tol) >>> FRAC)) begin
            v.parallel   = 1'b1;
            v.intersects = point_on_seg(ax0, ay0, ax1, ay1, bx0, by0, tol) ||
                           point_on_seg(ax0, ay0, ax1, ay1, bx1, by1, tol) ||
                           point_on_seg(bx0, by0, bx1, by1, ax0, ay0, tol) ||
                           point_on_seg(bx0, by0, bx1, by1, ax1, ay1, tol);
        end else begin
            nx = 128'(ab) * 128'(bc) - 128'(bb) * 128'(ac);
            ny = 128'(ba) * 128'(ac) - 128'(aa) * 128'(bc);
            if (det < 0) begin
                nx = -nx;
                ny = -ny;
            end
            xq = crossing_coord(nx, dmag);
            yq = crossing_coord(ny, dmag);
            v.intersects = box_hit(ax0, ay0, ax1, ay1, xq, yq, tol) &&
                           box_hit(bx0, by0, bx1, by1, xq, yq, tol);
        end
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------

    // Offers one beat; inputs change on the falling edge only. An idle gap
    // (start low, random segs) may come first. Expectation is queued at acceptance.
    task automatic send_pair(input sit_in_t p, input bit typed, input sit_out_t answer);
        int gap;
        gap = 0;
        if (idle_enable && $urandom_range(99) < 10)
            gap = 1;
        repeat (gap) begin
            @(negedge clk);
            start <= 1'b0;
            segs  <= sit_in_t'({$urandom, $urandom, $urandom, $urandom, $urandom,
                                $urandom, $urandom, $urandom});
        end
        @(negedge clk);
        start <= 1'b1;
        segs  <= p;
        forever begin
            @(posedge clk);
            if (!busy) break;
        end
        verdicts_pending.push_back(typed ? answer : predict_contact(p, tol_shadow));
        beat_count++;
    endtask

    task automatic drop_start();
        @(negedge clk);
        start <= 1'b0;
    endtask

    // Register writes only with the pipeline drained.
    task automatic write_tolerance(input logic [TOL_BITS-1:0] val);
        drop_start();
        wait (verdicts_pending.size() == 0);
        repeat (LATENCY_SLACK) @(posedge clk);
        @(negedge clk);
        tol_we    <= 1'b1;
        tol_wdata <= val;
        @(negedge clk);
        tol_we    <= 1'b0;
        tol_shadow = val;
    endtask

    // Mix of shapes; small grids are where parallel and touching cases live.
    function automatic sit_in_t random_pair();
        sit_in_t p;
        int      kind;
        int      r;
        logic signed [15:0] dx, dy, ox, oy;
        kind = $urandom_range(99);
        p = sit_in_t'({$urandom, $urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom, $urandom});
        r = $urandom_range(1, 3) == 1 ? 200 : 8;
        if (kind >= 25) begin
            p.a_start_x = 16'($urandom_range(2 * r) - r);
            p.a_start_y = 16'($urandom_range(2 * r) - r);
            p.a_end_x   = 16'($urandom_range(2 * r) - r);
            p.a_end_y   = 16'($urandom_range(2 * r) - r);
            p.b_start_x = 16'($urandom_range(2 * r) - r);
            p.b_start_y = 16'($urandom_range(2 * r) - r);
            p.b_end_x   = 16'($urandom_range(2 * r) - r);
            p.b_end_y   = 16'($urandom_range(2 * r) - r);
        end
        if (kind >= 60) begin
            // b parallel to a, offset; often collinear
            dx = p.a_end_x - p.a_start_x;
            dy = p.a_end_y - p.a_start_y;
            ox = 16'($urandom_range(6) - 3);
            oy = ($urandom_range(1)) ? 16'(ox * dy / ((dx == 0) ? 16'sd1 : dx))
                                     : 16'($urandom_range(4) - 2);
            if (kind >= 80) begin
                ox = 16'(dx * ($urandom_range(4) - 2) / 2);
                oy = 16'(dy * ($urandom_range(4) - 2) / 2);
            end
            p.b_start_x = p.a_start_x + ox;
            p.b_start_y = p.a_start_y + oy;
            p.b_end_x   = p.b_start_x + (($urandom_range(1)) ? -dx : dx);
            p.b_end_y   = p.b_start_y + ((p.b_end_x == p.b_start_x + dx) ? dy : -dy);
        end
        if (kind < 5) begin
            p.b_end_x = p.b_start_x;
            p.b_end_y = p.b_start_y;
        end else if (kind < 8) begin
            p.a_end_x = p.a_start_x;
            p.a_end_y = p.a_start_y;
        end
        return p;
    endfunction

    // ------------------------------------------------------------------
    // Result checking: done is a one-cycle strobe, no stall possible
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        sit_out_t want;
        if (rst_n && done) begin
            if (verdicts_pending.size() == 0) begin
                report_mismatch("result beat with nothing expected");
            end else begin
                want = verdicts_pending.pop_front();
                if (result.intersects !== want.intersects)
                    report_mismatch($sformatf("intersects got %b want %b",
                                              result.intersects, want.intersects));
                if (result.parallel !== want.parallel)
                    report_mismatch($sformatf("parallel got %b want %b",
                                              result.parallel, want.parallel));
                if (result.status !== want.status)
                    report_mismatch($sformatf("status got %b want %b",
                                              result.status, want.status));
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    pair_row_t directed_rows[$];

    function automatic pair_row_t mk_row(int ax0, int ay0, int ax1, int ay1,
                                         int bx0, int by0, int bx1, int by1,
                                         bit typed, bit hit, bit par, bit st);
        pair_row_t row;
        row.pair = '{16'(ax0), 16'(ay0), 16'(ax1), 16'(ay1),
                     16'(bx0), 16'(by0), 16'(bx1), 16'(by1)};
        row.typed  = typed;
        row.answer = '{hit, par, st};
        return row;
    endfunction

    initial begin
        logic [TOL_BITS-1:0] tol_plan[4];
        rst_n       = 1'b0;
        start       = 1'b0;
        segs        = '0;
        tol_we      = 1'b0;
        tol_wdata   = '0;
        tol_shadow  = TOL_RESET;
        err_count   = 0;
        beat_count  = 0;
        idle_enable = 1'b1;

        // degenerate segments
        directed_rows.push_back(mk_row(0, 0, 0, 0, 0, 0, 1, 1, 1, 0, 0, 1));
        directed_rows.push_back(mk_row(0, 0, 1, 1, 3, 3, 3, 3, 1, 0, 0, 1));
        directed_rows.push_back(mk_row(32767, 32767, 32767, 32767,
                                       -32768, -32768, -32768, -32768, 1, 0, 0, 1));
        // plain crossing, touching at endpoint, clear miss
        directed_rows.push_back(mk_row(-10, -10, 10, 10, -10, 10, 10, -10, 1, 1, 0, 0));
        directed_rows.push_back(mk_row(0, 0, 10, 10, 10, 10, 20, 0, 1, 1, 0, 0));
        directed_rows.push_back(mk_row(0, 0, 1, 1, 5, 0, 6, -1, 0, 0, 0, 0));
        // parallel: overlapping collinear, disjoint collinear, offset lines, end-touching collinear
        directed_rows.push_back(mk_row(0, 0, 10, 0, 5, 0, 15, 0, 1, 1, 1, 0));
        directed_rows.push_back(mk_row(0, 0, 10, 0, 11, 0, 15, 0, 1, 0, 1, 0));
        directed_rows.push_back(mk_row(0, 0, 10, 0, 0, 1, 10, 1, 1, 0, 1, 0));
        directed_rows.push_back(mk_row(0, 0, 10, 0, 10, 0, 20, 0, 1, 1, 1, 0));
        // field extremes
        directed_rows.push_back(mk_row(-32768, -32768, 32767, 32767,
                                       -32768, 32767, 32767, -32768, 0, 0, 0, 0));
        directed_rows.push_back(mk_row(-32768, -32768, 32767, -32768,
                                       -32768, 32767, 32767, 32767, 1, 0, 1, 0));
        directed_rows.push_back(mk_row(-32768, 0, 32767, 0, 0, -32768, 0, 32767, 1, 1, 0, 0));
        directed_rows.push_back(mk_row(32767, -32768, -32768, 32767,
                                       -32768, -32768, 32767, 32767, 0, 0, 0, 0));
        directed_rows.push_back(mk_row(-32768, -32768, -32767, -32767,
                                       32766, 32766, 32767, 32767, 1, 0, 1, 0));
        // near miss, crossing point rounding at the box edge
        directed_rows.push_back(mk_row(0, 0, 3, 1, 1, 0, 1, 1, 0, 0, 0, 0));
        directed_rows.push_back(mk_row(0, 0, 3, 1, 4, 0, 4, 5, 0, 0, 0, 0));
        directed_rows.push_back(mk_row(1, 2, 7, 3, -5, 9, 2, -4, 0, 0, 0, 0));

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
            send_pair(directed_rows[i].pair, directed_rows[i].typed, directed_rows[i].answer);

        // Random phases under several tolerance settings, extremes included.
        tol_plan[0] = TOL_RESET;
        tol_plan[1] = '0;
        tol_plan[2] = '1;
        tol_plan[3] = TOL_BITS'($urandom);
        for (int ph = 0; ph < 4; ph++) begin
            if (ph != 0)
                write_tolerance(tol_plan[ph]);
            for (int n = 0; n < 270; n++) begin
                // long run with no gaps in the middle of the second phase
                idle_enable = !(ph == 1 && n >= 50 && n < 250);
                send_pair(random_pair(), 1'b0, '0);
            end
        end
        drop_start();

        wait (verdicts_pending.size() == 0);
        repeat (LATENCY_SLACK) @(posedge clk);
        if (err_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
